// File: src/sdhh_pkg.sv
// Shared types and constants of the straight drive heading hold block.
// Used by every module in src but sdhh_checker; depends on nothing else.
package sdhh_pkg;

   // Command codes carried in req_tuser.
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_ABORT = 2'd2;

   // Configuration register indexes.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_CM_PER_COUNT = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_P       = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN_D       = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPEED_FAST   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPEED_SLOW   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPEED_MAX    = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLOW_ZONE    = 3'd6;

   localparam int unsigned TRAVEL_W = 48;

   // Heading wrap limits in centidegrees.
   localparam logic signed [18:0] WRAP_HALF   = 19'sd18000;
   localparam logic signed [18:0] WRAP_FULL   = 19'sd36000;
   localparam logic signed [18:0] WRAP_THREE  = 19'sd54000;
   localparam logic signed [18:0] WRAP_DOUBLE = 19'sd72000;

   // One accepted input item as held in the input register.
   typedef struct packed {
      logic              hold_heading;
      logic signed [15:0] target_heading;
      logic [15:0]       target_distance;
      logic signed [15:0] yaw;
      logic signed [15:0] right_enc;
      logic signed [15:0] left_enc;
      logic [1:0]        cmd;
   } req_item_type;

   // Distance status handed from the travel unit to the control logic.
   typedef struct packed {
      logic reached;
      logic slow;
   } travel_status_type;

endpackage

// File: src/sdhh_travel.sv
// Distance accumulation: mean absolute encoder step, saturating add, target compare.
// Depends on sdhh_pkg.
module sdhh_travel
   import sdhh_pkg::*;
(
   input  logic [TRAVEL_W-1:0] travelled,
   input  logic [15:0]         goal_distance,
   input  logic [15:0]         cm_per_count,
   input  logic [7:0]          slow_zone_cm,
   input  logic signed [15:0]  left_enc,
   input  logic signed [15:0]  right_enc,
   output logic [TRAVEL_W-1:0] travelled_next,
   output travel_status_type   status
);

   logic [16:0]         abs_left;
   logic [16:0]         abs_right;
   logic [16:0]         count_sum;
   logic [32:0]         product;
   logic [31:0]         step;
   logic [TRAVEL_W:0]   total;
   logic [TRAVEL_W-1:0] goal;
   logic [31:0]         remaining;

   always_comb begin
      abs_left  = left_enc[15]  ? (17'd0 - 17'(left_enc))  : 17'(left_enc);
      abs_right = right_enc[15] ? (17'd0 - 17'(right_enc)) : 17'(right_enc);
      count_sum = abs_left + abs_right;
      product   = 33'(count_sum) * 33'(cm_per_count);
      step      = product[32:1];
      total     = {1'b0, travelled} + (TRAVEL_W + 1)'(step);
      travelled_next = total[TRAVEL_W] ? '1 : total[TRAVEL_W-1:0];
      goal      = {16'd0, goal_distance, 16'd0};
      // Only meaningful below the goal, where both values fit in 32 bits.
      remaining = goal[31:0] - travelled_next[31:0];
      status.reached = (travelled_next >= goal);
      status.slow    = (remaining < {8'd0, slow_zone_cm, 16'd0});
   end

endmodule

// File: src/sdhh_steer.sv
// Heading error wrap and PD turn term with truncating Q12 scale and 16-bit saturation.
// Depends on sdhh_pkg.
module sdhh_steer
   import sdhh_pkg::*;
(
   input  logic signed [15:0] goal_heading,
   input  logic signed [15:0] yaw,
   input  logic signed [15:0] prior_error,
   input  logic [15:0]        gain_p,
   input  logic [15:0]        gain_d,
   output logic signed [15:0] heading_error,
   output logic signed [15:0] turn
);

   logic signed [18:0] diff;
   logic signed [18:0] wrapped;
   logic signed [16:0] err_delta;
   logic signed [16:0] gain_p_s;
   logic signed [16:0] gain_d_s;
   logic signed [32:0] prod_p;
   logic signed [33:0] prod_d;
   logic signed [34:0] acc;
   logic signed [34:0] acc_adj;
   logic signed [22:0] quot;

   always_comb begin
      diff = 19'(goal_heading) - 19'(yaw);
      if (diff > WRAP_THREE) begin
         wrapped = diff - WRAP_DOUBLE;
      end else if (diff > WRAP_HALF) begin
         wrapped = diff - WRAP_FULL;
      end else if (diff < -WRAP_THREE) begin
         wrapped = diff + WRAP_DOUBLE;
      end else if (diff < -WRAP_HALF) begin
         wrapped = diff + WRAP_FULL;
      end else begin
         wrapped = diff;
      end
      heading_error = wrapped[15:0];

      err_delta = 17'(heading_error) - 17'(prior_error);
      gain_p_s  = $signed({1'b0, gain_p});
      gain_d_s  = $signed({1'b0, gain_d});
      prod_p    = 33'(gain_p_s) * 33'(heading_error);
      prod_d    = 34'(gain_d_s) * 34'(err_delta);
      acc       = 35'(prod_p) + 35'(prod_d);
      // Bias negative values so the shift truncates toward zero.
      acc_adj   = acc + (acc[34] ? 35'sd4095 : 35'sd0);
      quot      = acc_adj[34:12];
      if (quot > 23'sd32767) begin
         turn = 16'sd32767;
      end else if (quot < -23'sd32768) begin
         turn = -16'sd32768;
      end else begin
         turn = quot[15:0];
      end
   end

endmodule

// File: src/straight_drive_heading_hold.sv
// Each accepted item is held in the input register until the result register is free to take it.
// Throughput: one item per cycle while results are taken; the travel multiply-add and the PD
// multiply-add sit side by side in the single combinational pass between input and result registers.
// Reset is synchronous and active high: both registers empty, all segment state cleared to zero
// and the configuration registers back at their defaults; no clearing pass is needed.
// Top level; depends on sdhh_pkg, sdhh_travel and sdhh_steer.
module straight_drive_heading_hold
   import sdhh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input items.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata, lowest bit up: left_enc[15:0], right_enc[31:16], yaw[47:32],
   // target_distance[63:48], target_heading[79:64], hold_heading[80], zeros[87:81]
   input  logic [87:0]           req_tdata,
   // tuser: cmd[1:0]
   input  logic [1:0]            req_tuser,
   // Result items.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata, lowest bit up: left_drive[14:0], right_drive[29:15], turn_drive[45:30],
   // heading_error[61:46], running[62], finished[63], stop_now[64], zeros[71:65]
   output logic [71:0]           rsp_tdata,
   // Configuration writes.
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [15:0]           csr_wdata
);

   // The input register holds one accepted item until the result register can take its
   // result, so the producer only waits when both registers are full and the consumer stalls.
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   logic [71:0]  out_data_ff;
   logic         fire;

   // Configuration registers.
   logic [15:0] cm_per_count_ff;
   logic [15:0] gain_p_ff;
   logic [15:0] gain_d_ff;
   logic [14:0] speed_fast_ff;
   logic [14:0] speed_slow_ff;
   logic [14:0] speed_max_ff;
   logic [7:0]  slow_zone_ff;

   // Segment state and its next values.
   logic                  running_ff,      running_in;
   logic                  finished_ff,     finished_in;
   logic [TRAVEL_W-1:0]   travelled_ff,    travelled_in;
   logic [15:0]           goal_dist_ff,    goal_dist_in;
   logic signed [15:0]    goal_head_ff,    goal_head_in;
   logic signed [15:0]    prior_err_ff,    prior_err_in;
   logic [14:0]           last_left_ff,    last_left_in;
   logic [14:0]           last_right_ff,   last_right_in;
   logic signed [15:0]    last_turn_ff,    last_turn_in;
   logic signed [15:0]    last_err_ff,     last_err_in;
   logic                  stop_now;

   logic [TRAVEL_W-1:0]   travelled_next;
   travel_status_type     travel_status;
   logic signed [15:0]    heading_error;
   logic signed [15:0]    turn;
   logic [14:0]           base_speed;
   logic signed [17:0]    base_s;
   logic signed [17:0]    left_wide;
   logic signed [17:0]    right_wide;
   logic signed [17:0]    max_s;

   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.cmd             <= req_tuser;
         in_item_ff.left_enc        <= req_tdata[15:0];
         in_item_ff.right_enc       <= req_tdata[31:16];
         in_item_ff.yaw             <= req_tdata[47:32];
         in_item_ff.target_distance <= req_tdata[63:48];
         in_item_ff.target_heading  <= req_tdata[79:64];
         in_item_ff.hold_heading    <= req_tdata[80];
      end
   end

   // Configuration writes must arrive only while the block is idle, so that no item sees a
   // register change in the middle of its work; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         cm_per_count_ff <= 16'd1000;
         gain_p_ff       <= 16'd512;
         gain_d_ff       <= 16'd256;
         speed_fast_ff   <= 15'd600;
         speed_slow_ff   <= 15'd300;
         speed_max_ff    <= 15'd1000;
         slow_zone_ff    <= 8'd20;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_CM_PER_COUNT: cm_per_count_ff <= csr_wdata;
            CSR_GAIN_P:       gain_p_ff       <= csr_wdata;
            CSR_GAIN_D:       gain_d_ff       <= csr_wdata;
            CSR_SPEED_FAST:   speed_fast_ff   <= csr_wdata[14:0];
            CSR_SPEED_SLOW:   speed_slow_ff   <= csr_wdata[14:0];
            CSR_SPEED_MAX:    speed_max_ff    <= csr_wdata[14:0];
            CSR_SLOW_ZONE:    slow_zone_ff    <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   sdhh_travel u_travel (
      .travelled      (travelled_ff),
      .goal_distance  (goal_dist_ff),
      .cm_per_count   (cm_per_count_ff),
      .slow_zone_cm   (slow_zone_ff),
      .left_enc       (in_item_ff.left_enc),
      .right_enc      (in_item_ff.right_enc),
      .travelled_next (travelled_next),
      .status         (travel_status)
   );

   sdhh_steer u_steer (
      .goal_heading  (goal_head_ff),
      .yaw           (in_item_ff.yaw),
      .prior_error   (prior_err_ff),
      .gain_p        (gain_p_ff),
      .gain_d        (gain_d_ff),
      .heading_error (heading_error),
      .turn          (turn)
   );

   // Wheel drives: base speed minus and plus the turn term, computed at 18 bits so that
   // nothing wraps, then clamped to the range from zero to the maximum speed.
   always_comb begin
      base_speed = travel_status.slow ? speed_slow_ff : speed_fast_ff;
      base_s     = $signed({3'd0, base_speed});
      max_s      = $signed({3'd0, speed_max_ff});
      left_wide  = base_s - 18'(turn);
      right_wide = base_s + 18'(turn);
   end

   always_comb begin
      running_in    = running_ff;
      finished_in   = finished_ff;
      travelled_in  = travelled_ff;
      goal_dist_in  = goal_dist_ff;
      goal_head_in  = goal_head_ff;
      prior_err_in  = prior_err_ff;
      last_left_in  = last_left_ff;
      last_right_in = last_right_ff;
      last_turn_in  = last_turn_ff;
      last_err_in   = last_err_ff;
      stop_now      = 1'b0;

      unique case (in_item_ff.cmd)
         CMD_START: begin
            // A start is honoured in any state and opens a fresh segment.
            travelled_in  = '0;
            goal_dist_in  = in_item_ff.target_distance;
            goal_head_in  = in_item_ff.hold_heading ? in_item_ff.yaw
                                                    : in_item_ff.target_heading;
            prior_err_in  = '0;
            last_left_in  = '0;
            last_right_in = '0;
            last_turn_in  = '0;
            last_err_in   = '0;
            finished_in   = 1'b0;
            running_in    = 1'b1;
         end
         CMD_ABORT: begin
            // The held drive values are kept and repeated.
            finished_in = 1'b1;
            running_in  = 1'b0;
         end
         CMD_TICK: begin
            if (running_ff && !finished_ff) begin
               travelled_in = travelled_next;
               if (travel_status.reached) begin
                  // The heading error keeps its last value at the stop.
                  last_left_in  = '0;
                  last_right_in = '0;
                  last_turn_in  = '0;
                  finished_in   = 1'b1;
                  running_in    = 1'b0;
                  stop_now      = 1'b1;
               end else begin
                  prior_err_in = heading_error;
                  last_err_in  = heading_error;
                  last_turn_in = turn;
                  if (left_wide < 18'sd0) begin
                     last_left_in = '0;
                  end else if (left_wide > max_s) begin
                     last_left_in = speed_max_ff;
                  end else begin
                     last_left_in = left_wide[14:0];
                  end
                  if (right_wide < 18'sd0) begin
                     last_right_in = '0;
                  end else if (right_wide > max_s) begin
                     last_right_in = speed_max_ff;
                  end else begin
                     last_right_in = right_wide[14:0];
                  end
               end
            end
         end
         default: begin
            // The unused code behaves as an idle tick.
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= 1'b0;
         finished_ff   <= 1'b0;
         travelled_ff  <= '0;
         goal_dist_ff  <= '0;
         goal_head_ff  <= '0;
         prior_err_ff  <= '0;
         last_left_ff  <= '0;
         last_right_ff <= '0;
         last_turn_ff  <= '0;
         last_err_ff   <= '0;
      end else if (fire) begin
         running_ff    <= running_in;
         finished_ff   <= finished_in;
         travelled_ff  <= travelled_in;
         goal_dist_ff  <= goal_dist_in;
         goal_head_ff  <= goal_head_in;
         prior_err_ff  <= prior_err_in;
         last_left_ff  <= last_left_in;
         last_right_ff <= last_right_in;
         last_turn_ff  <= last_turn_in;
         last_err_ff   <= last_err_in;
      end
   end

   // The result register drains when taken and reloads in the same cycle when another
   // item is ready, which keeps a steady stream at one item per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= {7'd0, stop_now, finished_in, running_in, last_err_in,
                         last_turn_in, last_right_in, last_left_in};
      end
   end

endmodule

// File: src/sdhh_checker.sv
// Port-level checks on the result stream of straight_drive_heading_hold, and the bind
// that attaches them. Depends on the top level's port names only.
module sdhh_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   // A result leaves the register empty after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // The stop tick ends the segment with the drives zeroed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64] |-> !rsp_tdata[62] && rsp_tdata[63] &&
         rsp_tdata[14:0] == 15'd0 && rsp_tdata[29:15] == 15'd0 && rsp_tdata[45:30] == 16'd0)
      else $error("stop result with drives or wrong status");

   // Running and finished exclude each other.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[62] && rsp_tdata[63]))
      else $error("running and finished both set");

   // The wrapped heading error stays within half a turn.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[61:46]) <= 16'sd18000 &&
         $signed(rsp_tdata[61:46]) >= -16'sd18000)
      else $error("heading error outside half a turn");

endmodule

bind straight_drive_heading_hold sdhh_checker u_sdhh_checker (.*);
